### src/nmqmb_pkg.sv
// Package with the word types, operation codes, status codes and controller states.
`default_nettype none
package nmqmb_pkg;

  // Operation codes carried in func.
  localparam logic [1:0] FUNC_REGISTER = 2'd0;
  localparam logic [1:0] FUNC_PUSH     = 2'd1;
  localparam logic [1:0] FUNC_POP      = 2'd2;

  // Result status codes.
  typedef enum logic [2:0] {
    STAT_OK         = 3'd0,
    STAT_EMPTY      = 3'd1,
    STAT_NOT_FOUND  = 3'd2,
    STAT_TABLE_FULL = 3'd3,
    STAT_QUEUE_FULL = 3'd4
  } status_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_DESC,
    S_POP
  } state_t;

  // One input word.
  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] dest_name;
    logic [15:0] socket_handle;
    logic [2:0]  queue_index;
    logic [63:0] payload;
  } request_t;

  // One result word.
  typedef struct packed {
    status_t     status;
    logic [2:0]  slot_index;
    logic [63:0] popped_payload;
    logic [15:0] popped_handle;
    logic [3:0]  registered_count;
  } result_t;

endpackage
`default_nettype wire

### src/nmqmb_slot_table.sv
// Destination slot table: used flags, stored names, name search and free-slot search.
`default_nettype none
module nmqmb_slot_table #(
  parameter int NUM_QUEUES = 8,
  parameter int NAME_BITS  = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic [NAME_BITS-1:0]            name,
  input  wire logic                            claim,
  input  wire logic [$clog2(NUM_QUEUES)-1:0]   claim_slot,
  output logic      [NUM_QUEUES-1:0]           used,
  output logic                                 free_hit,
  output logic      [$clog2(NUM_QUEUES)-1:0]   free_slot,
  output logic                                 match_hit,
  output logic      [$clog2(NUM_QUEUES)-1:0]   match_slot,
  output logic      [$clog2(NUM_QUEUES+1)-1:0] count
);

  localparam int SLOT_W  = $clog2(NUM_QUEUES);
  localparam int COUNT_W = $clog2(NUM_QUEUES + 1);

  logic [NAME_BITS-1:0] name_table [NUM_QUEUES];

  // Used flags and the registered count are control state and reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      used  <= '0;
      count <= '0;
    end else if (claim) begin
      used[claim_slot] <= 1'b1;
      count            <= count + COUNT_W'(1);
    end
  end

  // Names are only read for slots whose used flag is set.
  always_ff @(posedge clk) begin
    if (claim) begin
      name_table[claim_slot] <= name;
    end
  end

  // Priority searches: scanning downwards leaves the lowest hit in place.
  always_comb begin
    free_hit   = 1'b0;
    free_slot  = '0;
    match_hit  = 1'b0;
    match_slot = '0;
    for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_hit  = 1'b1;
        free_slot = SLOT_W'(i);
      end
      if (used[i] && (name_table[i] == name)) begin
        match_hit  = 1'b1;
        match_slot = SLOT_W'(i);
      end
    end
  end

endmodule
`default_nettype wire

### src/named_multi_queue_message_buffer.sv
// Top level of the named multi-queue message buffer.
//
// Each word issued with start while busy is low (register, push, pop, or an unused
// code, which returns OK) produces exactly one result word, shown on response for a
// single cycle with done high; the receiver cannot stall. The name and free-slot
// search and the read of the per-queue descriptor memory take place together in
// S_LOOK, the result is formed in S_DESC, and a pop that returns data goes on to
// S_POP for the message memory read before the result strobe. A new word may be
// issued in the cycle that the previous result is strobed. No clearing pass is
// needed after reset.
`default_nettype none
module named_multi_queue_message_buffer
  import nmqmb_pkg::*;
#(
  parameter int NUM_QUEUES   = 8,
  parameter int QUEUE_DEPTH  = 16,
  parameter int NAME_BYTES   = 8,
  parameter int PAYLOAD_BITS = 64
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire request_t request,
  output logic          busy,
  output logic          done,
  output result_t       response
);

  localparam int NAME_BITS = NAME_BYTES * 8;
  localparam int SLOT_W    = $clog2(NUM_QUEUES);
  localparam int COUNT_W   = $clog2(NUM_QUEUES + 1);
  localparam int PTR_W     = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int MSG_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
  localparam int ADDR_W    = $clog2(MSG_DEPTH);

  // Per-queue descriptor held in the descriptor memory.
  typedef struct packed {
    logic [15:0]       handle;
    logic [PTR_W-1:0]  rd_ptr;
    logic [PTR_W-1:0]  wr_ptr;
    logic [FILL_W-1:0] fill;
  } desc_t;

  // Next ring position with wrap at the queue depth.
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  // Message memory address of one ring entry.
  function automatic logic [ADDR_W-1:0] msg_addr(input logic [SLOT_W-1:0] s,
                                                 input logic [PTR_W-1:0]  p);
    return ADDR_W'(s) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(p);
  endfunction

  state_t state, state_next;

  // Captured word, name and payload trimmed to their configured widths.
  logic [1:0]              req_func;
  logic [NAME_BITS-1:0]    req_name;
  logic [15:0]             req_handle;
  logic [2:0]              req_qidx;
  logic [PAYLOAD_BITS-1:0] req_payload;

  // Slot table signals.
  logic [NUM_QUEUES-1:0] used;
  logic                  free_hit, match_hit, claim;
  logic [SLOT_W-1:0]     free_slot, match_slot;
  logic [COUNT_W-1:0]    dest_count;

  // Lookup results carried into the descriptor cycle.
  logic              hit, hit_next;
  logic [SLOT_W-1:0] slot, slot_next;
  logic              pop_in_range;

  // Memories and their ports.
  desc_t                   desc_mem [NUM_QUEUES];
  logic [PAYLOAD_BITS-1:0] msg_mem  [MSG_DEPTH];
  desc_t                   desc_rd, desc_wdata;
  logic                    desc_re, desc_we;
  logic [PAYLOAD_BITS-1:0] msg_rd;
  logic                    msg_re, msg_we;
  logic [ADDR_W-1:0]       msg_raddr, msg_waddr;

  // Result register.
  result_t res_q, res_next;
  logic    res_load;

  nmqmb_slot_table #(
    .NUM_QUEUES (NUM_QUEUES),
    .NAME_BITS  (NAME_BITS)
  ) u_slot_table (
    .clk        (clk),
    .rst        (rst),
    .name       (req_name),
    .claim      (claim),
    .claim_slot (slot),
    .used       (used),
    .free_hit   (free_hit),
    .free_slot  (free_slot),
    .match_hit  (match_hit),
    .match_slot (match_slot),
    .count      (dest_count)
  );

  assign busy = (state != S_IDLE);

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= res_load;
    end
  end

  // Captured word and lookup results; no reset is needed on payload.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      req_func    <= request.func;
      req_name    <= request.dest_name[NAME_BITS-1:0];
      req_handle  <= request.socket_handle;
      req_qidx    <= request.queue_index;
      req_payload <= request.payload[PAYLOAD_BITS-1:0];
    end
    if (state == S_LOOK) begin
      hit  <= hit_next;
      slot <= slot_next;
    end
    if (res_load) begin
      res_q <= res_next;
    end
  end

  // Descriptor memory: one read port, one write port.
  always_ff @(posedge clk) begin
    if (desc_re) begin
      desc_rd <= desc_mem[slot_next];
    end
    if (desc_we) begin
      desc_mem[slot] <= desc_wdata;
    end
  end

  // Message memory: one read port, one write port.
  always_ff @(posedge clk) begin
    if (msg_re) begin
      msg_rd <= msg_mem[msg_raddr];
    end
    if (msg_we) begin
      msg_mem[msg_waddr] <= req_payload;
    end
  end

  assign pop_in_range = (int'(req_qidx) < NUM_QUEUES);

  // Slot choice for the captured word.
  always_comb begin
    hit_next  = 1'b0;
    slot_next = free_slot;
    case (req_func)
      FUNC_REGISTER: begin
        hit_next  = free_hit;
        slot_next = free_slot;
      end
      FUNC_PUSH: begin
        hit_next  = match_hit;
        slot_next = match_slot;
      end
      FUNC_POP: begin
        slot_next = SLOT_W'(req_qidx);
        hit_next  = pop_in_range && used[SLOT_W'(req_qidx)];
      end
      default: begin
        hit_next = 1'b0;
      end
    endcase
  end

  // Sequencer: next state, memory strobes and result formation.
  always_comb begin
    state_next = state;
    desc_re    = 1'b0;
    desc_we    = 1'b0;
    desc_wdata = desc_rd;
    msg_re     = 1'b0;
    msg_we     = 1'b0;
    msg_raddr  = msg_addr(slot, desc_rd.rd_ptr);
    msg_waddr  = msg_addr(slot, desc_rd.wr_ptr);
    claim      = 1'b0;
    res_load   = 1'b0;
    res_next   = '0;
    res_next.status = STAT_OK;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        desc_re    = 1'b1;
        state_next = S_DESC;
      end
      S_DESC: begin
        res_load   = 1'b1;
        state_next = S_IDLE;
        case (req_func)
          FUNC_REGISTER: begin
            if (hit) begin
              claim             = 1'b1;
              desc_we           = 1'b1;
              desc_wdata        = '0;
              desc_wdata.handle = req_handle;
              res_next.slot_index = 3'(slot);
            end else begin
              res_next.status = STAT_TABLE_FULL;
            end
          end
          FUNC_PUSH: begin
            if (!hit) begin
              res_next.status = STAT_NOT_FOUND;
            end else if (desc_rd.fill == FILL_W'(QUEUE_DEPTH)) begin
              res_next.status     = STAT_QUEUE_FULL;
              res_next.slot_index = 3'(slot);
            end else begin
              msg_we              = 1'b1;
              desc_we             = 1'b1;
              desc_wdata.wr_ptr   = ptr_inc(desc_rd.wr_ptr);
              desc_wdata.fill     = desc_rd.fill + FILL_W'(1);
              res_next.slot_index = 3'(slot);
            end
          end
          FUNC_POP: begin
            res_next.slot_index = req_qidx;
            if (hit && desc_rd.fill != '0) begin
              msg_re            = 1'b1;
              desc_we           = 1'b1;
              desc_wdata.rd_ptr = ptr_inc(desc_rd.rd_ptr);
              desc_wdata.fill   = desc_rd.fill - FILL_W'(1);
              res_load          = 1'b0;
              state_next        = S_POP;
            end else begin
              res_next.status = STAT_EMPTY;
              if (hit) begin
                res_next.popped_handle = desc_rd.handle;
              end
            end
          end
          default: begin
            res_next.status = STAT_OK;
          end
        endcase
      end
      S_POP: begin
        res_load                = 1'b1;
        res_next.slot_index     = req_qidx;
        res_next.popped_payload = 64'(msg_rd);
        res_next.popped_handle  = desc_rd.handle;
        state_next              = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // The count field always reflects the table as it stands after the word.
  always_comb begin
    response                  = res_q;
    response.registered_count = 4'(dest_count);
  end

endmodule
`default_nettype wire
